[src/mlfq_pkg.sv]
`timescale 1ns / 1ps
package mlfq_pkg;

    localparam int NUM_LEVELS  = 3;
    localparam int QUEUE_DEPTH = 64;
    localparam int MAX_TASKS   = 64;

    localparam int ID_W    = 6;
    localparam int LVL_W   = 2;
    localparam int CMD_W   = 3;
    localparam int SLICE_W = 16;
    localparam int TICK_W  = 32;
    localparam int PD_W    = 8;
    localparam int STAT_W  = 2;
    localparam int CIDX_W  = 2;
    localparam int CDAT_W  = 32;

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int QRAM_D  = NUM_LEVELS * QUEUE_DEPTH;
    localparam int QADDR_W = $clog2(QRAM_D);
    localparam int PDA_W   = $clog2(MAX_TASKS);

    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_YIELD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RETIRE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POFF   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PON    = 3'd5;

    localparam logic [CIDX_W-1:0] REG_SLICE0 = 2'd0;
    localparam logic [CIDX_W-1:0] REG_SLICE1 = 2'd1;
    localparam logic [CIDX_W-1:0] REG_SLICE2 = 2'd2;
    localparam logic [CIDX_W-1:0] REG_BOOST  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_LVL = 2'd2;

    typedef struct packed {
        logic load;
        logic tick;
        logic bl_init;
        logic bl_next;
        logic boost_rd;
        logic boost_mv;
        logic boost_end;
        logic pd_rd;
        logic pd_wr;
        logic requeue;
        logic pick_rd;
        logic pick;
        logic add;
    } ctl_t;

    typedef struct packed {
        logic need_boost;
        logic bl_empty;
        logic bl_last;
        logic need_decide;
        logic any_ready;
    } sts_t;

endpackage

[src/mlfq_ram.sv]
`timescale 1ns / 1ps
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/mlfq_ctrl.sv]
`timescale 1ns / 1ps
module mlfq_ctrl
    import mlfq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CMD_W-1:0] cmd,
    input  sts_t             sts,
    output ctl_t             ctl,
    output logic             busy,
    output logic             done
);

    typedef enum logic [14:0] {
        S_IDLE    = 15'h0001,
        S_TICK    = 15'h0002,
        S_TCHK    = 15'h0004,
        S_BST_RD  = 15'h0008,
        S_BST_MV  = 15'h0010,
        S_BST_END = 15'h0020,
        S_DRD     = 15'h0040,
        S_DCHK    = 15'h0080,
        S_REQ     = 15'h0100,
        S_PICK_RD = 15'h0200,
        S_PICK    = 15'h0400,
        S_ADD     = 15'h0800,
        S_PRD     = 15'h1000,
        S_PWR     = 15'h2000,
        S_DONE    = 15'h4000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    case (cmd)
                        CMD_TICK:   state_next = S_TICK;
                        CMD_YIELD:  state_next = S_REQ;
                        CMD_ADD:    state_next = S_ADD;
                        CMD_RETIRE: state_next = S_PICK_RD;
                        CMD_POFF:   state_next = S_PRD;
                        CMD_PON:    state_next = S_PRD;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_TICK:
            begin
                ctl.tick    = 1'b1;
                ctl.bl_init = 1'b1;
                state_next  = S_TCHK;
            end
            S_TCHK:
            begin
                state_next = sts.need_boost ? S_BST_RD : S_DRD;
            end
            S_BST_RD:
            begin
                if (sts.bl_empty)
                begin
                    if (sts.bl_last)
                    begin
                        state_next = S_BST_END;
                    end
                    else
                    begin
                        ctl.bl_next = 1'b1;
                    end
                end
                else
                begin
                    ctl.boost_rd = 1'b1;
                    state_next   = S_BST_MV;
                end
            end
            S_BST_MV:
            begin
                ctl.boost_mv = 1'b1;
                state_next   = S_BST_RD;
            end
            S_BST_END:
            begin
                ctl.boost_end = 1'b1;
                state_next    = S_DRD;
            end
            S_DRD:
            begin
                ctl.pd_rd  = 1'b1;
                state_next = S_DCHK;
            end
            S_DCHK:
            begin
                state_next = sts.need_decide ? S_REQ : S_DONE;
            end
            S_REQ:
            begin
                ctl.requeue = 1'b1;
                state_next  = S_PICK_RD;
            end
            S_PICK_RD:
            begin
                ctl.pick_rd = 1'b1;
                state_next  = sts.any_ready ? S_PICK : S_DONE;
            end
            S_PICK:
            begin
                ctl.pick   = 1'b1;
                state_next = S_DONE;
            end
            S_ADD:
            begin
                ctl.add    = 1'b1;
                state_next = S_DONE;
            end
            S_PRD:
            begin
                ctl.pd_rd  = 1'b1;
                state_next = S_PWR;
            end
            S_PWR:
            begin
                ctl.pd_wr  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

[src/mlfq_dp.sv]
`timescale 1ns / 1ps
module mlfq_dp
    import mlfq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDAT_W-1:0]  cfg_data,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [ID_W-1:0]    task_id,
    input  logic [LVL_W-1:0]   level,
    input  ctl_t               ctl,
    output sts_t               sts,
    output logic [ID_W-1:0]    running_task,
    output logic [LVL_W-1:0]   running_level,
    output logic [SLICE_W-1:0] slice_left,
    output logic               switched,
    output logic               boosted,
    output logic [STAT_W-1:0]  status
);

    logic [SLICE_W-1:0] slice0_reg, slice1_reg, slice2_reg;
    logic [TICK_W-1:0]  period_reg;

    logic [CMD_W-1:0]   cmd_reg;
    logic [ID_W-1:0]    tid_reg;
    logic [LVL_W-1:0]   lvl_reg;

    logic [PTR_W-1:0]   head_reg [NUM_LEVELS];
    logic [PTR_W-1:0]   head_next [NUM_LEVELS];
    logic [FILL_W-1:0]  fill_reg [NUM_LEVELS];
    logic [FILL_W-1:0]  fill_next [NUM_LEVELS];

    logic [ID_W-1:0]    run_id_reg, run_id_next;
    logic [LVL_W-1:0]   run_lvl_reg, run_lvl_next;
    logic [SLICE_W-1:0] slice_reg, slice_next;
    logic [TICK_W-1:0]  ticks_reg, ticks_next;
    logic [TICK_W-1:0]  boost_mark_reg, boost_mark_next;
    logic [LVL_W-1:0]   bl_reg, bl_next;
    logic [LVL_W-1:0]   pick_lvl_reg, pick_lvl_next;
    logic               switched_reg, switched_next;
    logic               boosted_reg, boosted_next;
    logic [STAT_W-1:0]  status_reg, status_next;

    logic [MAX_TASKS-1:0] pd_valid_reg, pd_valid_next;
    logic                 pd_hit_reg, pd_hit_next;

    logic               push_en;
    logic [LVL_W-1:0]   push_lvl;
    logic [ID_W-1:0]    push_id;
    logic               pop_en;
    logic [LVL_W-1:0]   pop_lvl;

    logic               q_we;
    logic [QADDR_W-1:0] q_waddr, q_raddr;
    logic [ID_W-1:0]    q_rdata;

    logic               pd_we;
    logic [PDA_W-1:0]   pd_addr;
    logic [PD_W-1:0]    pd_wdata, pd_rdata, depth;

    logic               any_ready;
    logic [LVL_W-1:0]   first_lvl;
    logic [LVL_W-1:0]   up_lvl;
    logic               id_in_range;

    function automatic logic [QADDR_W-1:0] qaddr(input logic [LVL_W-1:0] l,
                                                 input logic [PTR_W-1:0] p);
        qaddr = QADDR_W'(l) * QADDR_W'(QUEUE_DEPTH) + QADDR_W'(p);
    endfunction

    function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W:0] v);
        wrap = (v >= (PTR_W+1)'(QUEUE_DEPTH)) ? PTR_W'(v - (PTR_W+1)'(QUEUE_DEPTH))
                                               : PTR_W'(v);
    endfunction

    function automatic logic [SLICE_W-1:0] slice_for(input logic [LVL_W-1:0] l);
        logic [SLICE_W-1:0] s;
        if (l == LVL_W'(0))
        begin
            s = slice0_reg;
        end
        else if (l == LVL_W'(1))
        begin
            s = slice1_reg;
        end
        else
        begin
            s = slice2_reg;
        end
        return s;
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice0_reg <= SLICE_W'(2);
            slice1_reg <= SLICE_W'(4);
            slice2_reg <= SLICE_W'(8);
            period_reg <= TICK_W'(100);
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_SLICE0: slice0_reg <= cfg_data[SLICE_W-1:0];
                REG_SLICE1: slice1_reg <= cfg_data[SLICE_W-1:0];
                REG_SLICE2: slice2_reg <= cfg_data[SLICE_W-1:0];
                REG_BOOST:  period_reg <= cfg_data[TICK_W-1:0];
                default:    period_reg <= period_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
            tid_reg <= task_id;
            lvl_reg <= level;
        end
    end

    always_comb
    begin
        any_ready = 1'b0;
        first_lvl = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (fill_reg[i] != '0)
            begin
                any_ready = 1'b1;
                first_lvl = LVL_W'(i);
            end
        end
    end

    assign up_lvl      = (run_lvl_reg < LVL_W'(NUM_LEVELS - 1)) ? run_lvl_reg + LVL_W'(1)
                                                                 : run_lvl_reg;
    assign id_in_range = (32'(run_id_reg) < MAX_TASKS);
    assign depth       = pd_hit_reg ? pd_rdata : '0;
    assign pd_addr     = PDA_W'(run_id_reg);

    assign sts.need_boost  = ((ticks_reg - boost_mark_reg) >= period_reg);
    assign sts.bl_empty    = (fill_reg[bl_reg] == '0);
    assign sts.bl_last     = (bl_reg == LVL_W'(NUM_LEVELS - 1));
    assign sts.need_decide = (slice_reg == '0) && (depth == '0);
    assign sts.any_ready   = any_ready;

    always_comb
    begin
        run_id_next     = run_id_reg;
        run_lvl_next    = run_lvl_reg;
        slice_next      = slice_reg;
        ticks_next      = ticks_reg;
        boost_mark_next = boost_mark_reg;
        bl_next         = bl_reg;
        pick_lvl_next   = pick_lvl_reg;
        switched_next   = switched_reg;
        boosted_next    = boosted_reg;
        status_next     = status_reg;
        pd_valid_next   = pd_valid_reg;
        pd_hit_next     = pd_hit_reg;
        push_en         = 1'b0;
        push_lvl        = '0;
        push_id         = '0;
        pop_en          = 1'b0;
        pop_lvl         = '0;
        q_raddr         = qaddr(bl_reg, head_reg[bl_reg]);
        pd_we           = 1'b0;
        pd_wdata        = depth;

        if (ctl.load)
        begin
            switched_next = 1'b0;
            boosted_next  = 1'b0;
            status_next   = ST_OK;
        end
        if (ctl.tick)
        begin
            ticks_next = ticks_reg + TICK_W'(1);
            if (slice_reg != '0)
            begin
                slice_next = slice_reg - SLICE_W'(1);
            end
        end
        if (ctl.bl_init)
        begin
            bl_next = LVL_W'(1);
        end
        if (ctl.bl_next)
        begin
            bl_next = bl_reg + LVL_W'(1);
        end
        if (ctl.boost_mv)
        begin
            push_en  = 1'b1;
            push_lvl = '0;
            push_id  = q_rdata;
            pop_en   = 1'b1;
            pop_lvl  = bl_reg;
        end
        if (ctl.boost_end)
        begin
            if (run_id_reg != '0)
            begin
                run_lvl_next = '0;
            end
            boost_mark_next = ticks_reg;
            boosted_next    = 1'b1;
        end
        if (ctl.pd_rd)
        begin
            pd_hit_next = id_in_range && pd_valid_reg[pd_addr];
        end
        if (ctl.requeue && (run_id_reg != '0))
        begin
            run_lvl_next = up_lvl;
            push_en      = 1'b1;
            push_lvl     = up_lvl;
            push_id      = run_id_reg;
        end
        if (ctl.pick_rd)
        begin
            switched_next = 1'b1;
            q_raddr       = qaddr(first_lvl, head_reg[first_lvl]);
            pick_lvl_next = first_lvl;
            if (!any_ready)
            begin
                run_id_next  = '0;
                run_lvl_next = '0;
                slice_next   = slice0_reg;
            end
        end
        if (ctl.pick)
        begin
            run_id_next  = q_rdata;
            run_lvl_next = pick_lvl_reg;
            slice_next   = slice_for(pick_lvl_reg);
            pop_en       = 1'b1;
            pop_lvl      = pick_lvl_reg;
        end
        if (ctl.add)
        begin
            if (32'(lvl_reg) >= NUM_LEVELS)
            begin
                status_next = ST_BAD_LVL;
            end
            else
            begin
                push_en  = 1'b1;
                push_lvl = lvl_reg;
                push_id  = tid_reg;
            end
        end
        if (ctl.pd_wr && id_in_range)
        begin
            pd_we                  = 1'b1;
            pd_valid_next[pd_addr] = 1'b1;
            if (cmd_reg == CMD_POFF)
            begin
                pd_wdata = (depth != '1) ? depth + PD_W'(1) : depth;
            end
            else
            begin
                pd_wdata = (depth != '0) ? depth - PD_W'(1) : depth;
            end
        end

        // queue push and pop
        q_we    = 1'b0;
        q_waddr = qaddr(push_lvl, wrap({1'b0, head_reg[push_lvl]}
                                       + (PTR_W+1)'(fill_reg[push_lvl])));
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            head_next[i] = head_reg[i];
            fill_next[i] = fill_reg[i];
            if (push_en && (push_lvl == LVL_W'(i)))
            begin
                if (fill_reg[i] >= FILL_W'(QUEUE_DEPTH))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    q_we         = 1'b1;
                    fill_next[i] = fill_reg[i] + FILL_W'(1);
                end
            end
            if (pop_en && (pop_lvl == LVL_W'(i)))
            begin
                head_next[i] = wrap({1'b0, head_reg[i]} + (PTR_W+1)'(1));
                fill_next[i] = fill_reg[i] - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            run_id_reg     <= '0;
            run_lvl_reg    <= '0;
            slice_reg      <= '0;
            ticks_reg      <= '0;
            boost_mark_reg <= '0;
            bl_reg         <= '0;
            pick_lvl_reg   <= '0;
            switched_reg   <= 1'b0;
            boosted_reg    <= 1'b0;
            status_reg     <= ST_OK;
            pd_valid_reg   <= '0;
            pd_hit_reg     <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i] <= head_next[i];
                fill_reg[i] <= fill_next[i];
            end
            run_id_reg     <= run_id_next;
            run_lvl_reg    <= run_lvl_next;
            slice_reg      <= slice_next;
            ticks_reg      <= ticks_next;
            boost_mark_reg <= boost_mark_next;
            bl_reg         <= bl_next;
            pick_lvl_reg   <= pick_lvl_next;
            switched_reg   <= switched_next;
            boosted_reg    <= boosted_next;
            status_reg     <= status_next;
            pd_valid_reg   <= pd_valid_next;
            pd_hit_reg     <= pd_hit_next;
        end
    end

    mlfq_ram #(
        .WIDTH (ID_W),
        .DEPTH (QRAM_D)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (push_id),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    mlfq_ram #(
        .WIDTH (PD_W),
        .DEPTH (MAX_TASKS)
    ) u_depth_ram (
        .clk   (clk),
        .we    (pd_we),
        .waddr (pd_addr),
        .wdata (pd_wdata),
        .raddr (pd_addr),
        .rdata (pd_rdata)
    );

    assign running_task  = run_id_reg;
    assign running_level = run_lvl_reg;
    assign slice_left    = slice_reg;
    assign switched      = switched_reg;
    assign boosted       = boosted_reg;
    assign status        = status_reg;

endmodule

[src/mlfq_task_scheduler_core.sv]
`timescale 1ns / 1ps
// channel   handshake                  payload
// command   start, busy                cmd, task_id, level
// result    done (one-cycle strobe)    running_task, running_level, slice_left,
//                                      switched, boosted, status
// config    cfg_valid, cfg_ready       cfg_index, cfg_data
//
// one command at a time: start is taken while busy is low, done pulses when
// the result is out; a tick can run a boost that moves every task queued
// at levels 1 and 2 to level 0, entry by entry through the queue ram
// (each entry is read out and written back, up to 2 * QUEUE_DEPTH entries)
// asynchronous reset empties the queues at once, no clearing pass
// the receiver cannot stall; cfg_ready is always high
module mlfq_task_scheduler_core
    import mlfq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [ID_W-1:0]    task_id,
    input  logic [LVL_W-1:0]   level,
    output logic               done,
    output logic [ID_W-1:0]    running_task,
    output logic [LVL_W-1:0]   running_level,
    output logic [SLICE_W-1:0] slice_left,
    output logic               switched,
    output logic               boosted,
    output logic [STAT_W-1:0]  status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDAT_W-1:0]  cfg_data
);

    ctl_t ctl;
    sts_t sts;

    assign cfg_ready = 1'b1;

    mlfq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    mlfq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr        (cfg_valid & cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .task_id       (task_id),
        .level         (level),
        .ctl           (ctl),
        .sts           (sts),
        .running_task  (running_task),
        .running_level (running_level),
        .slice_left    (slice_left),
        .switched      (switched),
        .boosted       (boosted),
        .status        (status)
    );

endmodule
